// File: design/sip_pkg.sv
// segment intersection point: shared payload types and fixed datapath widths
// used by the top level, the divider pipeline and the port checker
// no dependencies
package sip_pkg;

  // coordinate and datapath widths follow from the 16-bit coordinate fields
  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;      // difference of two coordinates
  localparam int unsigned ProdW  = 2 * DiffW;       // product of two differences
  localparam int unsigned SumW   = ProdW + 1;       // den, tnum, unum
  localparam int unsigned MagW   = ProdW;           // magnitude of den / tnum
  localparam int unsigned DMagW  = CoordW;          // magnitude of one delta
  localparam int unsigned NumW   = MagW + DMagW;    // |tnum| * |delta|
  localparam int unsigned PointW = 32;              // fixed-point result width

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [PointW-1:0] point_coord_t;

  // one input transaction: segment a-b and segment c-d
  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  // one output transaction
  typedef struct packed {
    logic         hit;
    point_coord_t cross_x;
    point_coord_t cross_y;
  } point_t;

  // per-item control that rides alongside the quotient pipeline
  typedef struct packed {
    logic   hit;
    coord_t start_x;
    coord_t start_y;
    logic   neg_x;
    logic   neg_y;
  } side_t;

endpackage

// File: design/sip_div_pipe.sv
// segment intersection point: pipelined restoring divider, two lanes sharing one divisor
// one quotient bit per stage; depends on sip_pkg
module sip_div_pipe #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  sip_pkg::side_t                         side_i,
  input  logic [sip_pkg::MagW-1:0]               den_i,
  input  logic [sip_pkg::NumW-1:0]               num_x_i,
  input  logic [sip_pkg::NumW-1:0]               num_y_i,
  output logic                                   valid_o,
  output sip_pkg::side_t                         side_o,
  output logic [sip_pkg::DMagW+FRAC_BITS-1:0]    quot_x_o,
  output logic [sip_pkg::DMagW+FRAC_BITS-1:0]    quot_y_o
);

  localparam int unsigned MagW  = sip_pkg::MagW;
  localparam int unsigned DMagW = sip_pkg::DMagW;
  localparam int unsigned NumW  = sip_pkg::NumW;
  localparam int unsigned QuotW = DMagW + FRAC_BITS;

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic            ge;
  } step_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic step_t div_step(input logic [MagW-1:0] rem, input logic bit_in,
                                     input logic [MagW-1:0] den);
    logic [MagW:0] trial;
    logic [MagW:0] diff;
    step_t         res;
    trial   = {rem, bit_in};
    diff    = trial - {1'b0, den};
    res.ge  = (trial >= {1'b0, den});
    res.rem = res.ge ? diff[MagW-1:0] : trial[MagW-1:0];
    return res;
  endfunction

  // stage registers: partial remainder, shifting dividend/quotient word, divisor
  logic [QuotW-1:0]  valid_q;
  sip_pkg::side_t    side_q  [QuotW];
  logic [MagW-1:0]   den_q   [QuotW];
  logic [MagW-1:0]   rem_x_q [QuotW];
  logic [MagW-1:0]   rem_y_q [QuotW];
  logic [QuotW-1:0]  low_x_q [QuotW];
  logic [QuotW-1:0]  low_y_q [QuotW];

  // stage inputs
  sip_pkg::side_t    feed_side  [QuotW];
  logic [MagW-1:0]   feed_den   [QuotW];
  logic [MagW-1:0]   feed_rem_x [QuotW];
  logic [MagW-1:0]   feed_rem_y [QuotW];
  logic [QuotW-1:0]  feed_low_x [QuotW];
  logic [QuotW-1:0]  feed_low_y [QuotW];

  // stage results
  step_t             step_x [QuotW];
  step_t             step_y [QuotW];
  logic [QuotW-1:0]  low_x_d [QuotW];
  logic [QuotW-1:0]  low_y_d [QuotW];

  always_comb begin
    // upper part of the dividend seeds the remainder, the rest shifts in
    feed_side[0]  = side_i;
    feed_den[0]   = den_i;
    feed_rem_x[0] = num_x_i[NumW-1:DMagW];
    feed_rem_y[0] = num_y_i[NumW-1:DMagW];
    feed_low_x[0] = {num_x_i[DMagW-1:0], {FRAC_BITS{1'b0}}};
    feed_low_y[0] = {num_y_i[DMagW-1:0], {FRAC_BITS{1'b0}}};
    for (int k = 1; k < QuotW; k++) begin
      feed_side[k]  = side_q[k-1];
      feed_den[k]   = den_q[k-1];
      feed_rem_x[k] = rem_x_q[k-1];
      feed_rem_y[k] = rem_y_q[k-1];
      feed_low_x[k] = low_x_q[k-1];
      feed_low_y[k] = low_y_q[k-1];
    end
    for (int k = 0; k < QuotW; k++) begin
      step_x[k]  = div_step(feed_rem_x[k], feed_low_x[k][QuotW-1], feed_den[k]);
      step_y[k]  = div_step(feed_rem_y[k], feed_low_y[k][QuotW-1], feed_den[k]);
      low_x_d[k] = {feed_low_x[k][QuotW-2:0], step_x[k].ge};
      low_y_d[k] = {feed_low_y[k][QuotW-2:0], step_y[k].ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[QuotW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QuotW; k++) begin
        side_q[k]  <= feed_side[k];
        den_q[k]   <= feed_den[k];
        rem_x_q[k] <= step_x[k].rem;
        rem_y_q[k] <= step_y[k].rem;
        low_x_q[k] <= low_x_d[k];
        low_y_q[k] <= low_y_d[k];
      end
    end
  end

  assign valid_o  = valid_q[QuotW-1];
  assign side_o   = side_q[QuotW-1];
  assign quot_x_o = low_x_q[QuotW-1];
  assign quot_y_o = low_y_q[QuotW-1];

endmodule

// File: design/segment_intersection_point.sv
// segment intersection point: top level with cross-product front end and output skid stage
// depends on sip_pkg and sip_div_pipe
//
// usage
//   input channel  in_valid_i / in_ready_o / in_data_i: one transaction carries two
//     segments a-b and c-d as signed integer endpoints
//   output channel out_valid_o / out_ready_i / out_data_o: one transaction per input,
//     in input order; hit is set when the segments cross strictly inside both
//     (touching at an end, parallel and collinear pairs give no hit), and then
//     cross_x / cross_y hold a + t(b - a) with FRAC_BITS fraction bits, truncated
//     toward zero before the add, wrapped to 32 bits; without a hit both are zero
//   pipeline: a result passes five front-end stages, then the one-bit-per-stage
//     divider of DMagW + FRAC_BITS stages, then the output register
//   throughput: one transaction per cycle while the receiver keeps out_ready_i high
//   stall: a held output fills a one-entry skid register while the pipeline keeps
//     moving; only a full skid register drops in_ready_o and freezes the pipeline
//   reset: asynchronous, clears all valid bits; in_ready_o is high right after it
module segment_intersection_point #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sip_pkg::seg_pair_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sip_pkg::point_t    out_data_o
);

  localparam int unsigned CoordW = sip_pkg::CoordW;
  localparam int unsigned DiffW  = sip_pkg::DiffW;
  localparam int unsigned ProdW  = sip_pkg::ProdW;
  localparam int unsigned SumW   = sip_pkg::SumW;
  localparam int unsigned MagW   = sip_pkg::MagW;
  localparam int unsigned DMagW  = sip_pkg::DMagW;
  localparam int unsigned NumW   = sip_pkg::NumW;
  localparam int unsigned PointW = sip_pkg::PointW;
  localparam int unsigned QuotW  = DMagW + FRAC_BITS;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // difference of two coordinates, one bit wider than either
  function automatic diff_t coord_diff(input sip_pkg::coord_t a, input sip_pkg::coord_t b);
    return {a[CoordW-1], a} - {b[CoordW-1], b};
  endfunction

  function automatic logic [MagW-1:0] sum_mag(input sum_t v);
    logic [SumW-1:0] a;
    a = v[SumW-1] ? -v : v;
    return a[MagW-1:0];
  endfunction

  function automatic logic [DMagW-1:0] diff_mag(input diff_t v);
    logic [DiffW-1:0] a;
    a = v[DiffW-1] ? -v : v;
    return a[DMagW-1:0];
  endfunction

  // whole pipeline moves together; it stops only while the skid register is full
  logic adv;
  logic skid_valid_q;

  assign adv        = !skid_valid_q;
  assign in_ready_o = adv;

  // stage 1: coordinate differences
  logic            s1_valid_q;
  diff_t           abx_q, aby_q, cdx_q, cdy_q, acx_q, acy_q;
  sip_pkg::coord_t s1_ax_q, s1_ay_q;

  // stage 2: six cross-product terms
  logic            s2_valid_q;
  prod_t           p_den_a_q, p_den_b_q, p_t_a_q, p_t_b_q, p_u_a_q, p_u_b_q;
  diff_t           s2_abx_q, s2_aby_q;
  sip_pkg::coord_t s2_ax_q, s2_ay_q;

  // stage 3: den, tnum, unum
  logic            s3_valid_q;
  sum_t            den_q, tnum_q, unum_q;
  diff_t           s3_abx_q, s3_aby_q;
  sip_pkg::coord_t s3_ax_q, s3_ay_q;

  // stage 4: range test and magnitudes
  logic             s4_valid_q;
  logic             t_ok, u_ok;
  logic [MagW-1:0]  mag_den, mag_tnum, mag_unum;
  logic [MagW-1:0]  tn_q, dn_q;
  logic [DMagW-1:0] mdx_q, mdy_q;
  sip_pkg::side_t   s4_side_d, s4_side_q;

  // stage 5: dividends |tnum| * |delta|
  logic             s5_valid_q;
  logic [NumW-1:0]  num_x_q, num_y_q;
  logic [MagW-1:0]  s5_dn_q;
  sip_pkg::side_t   s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  // range test: 0 < num/den < 1 means same nonzero sign and |num| < |den|
  always_comb begin
    mag_den   = sum_mag(den_q);
    mag_tnum  = sum_mag(tnum_q);
    mag_unum  = sum_mag(unum_q);
    t_ok      = (tnum_q != '0) && (den_q != '0) && (tnum_q[SumW-1] == den_q[SumW-1])
                && (mag_tnum < mag_den);
    u_ok      = (unum_q != '0) && (den_q != '0) && (unum_q[SumW-1] == den_q[SumW-1])
                && (mag_unum < mag_den);
    s4_side_d.hit     = t_ok && u_ok;
    s4_side_d.start_x = s3_ax_q;
    s4_side_d.start_y = s3_ay_q;
    // delta = b - a = -(a - b), negative when a - b is positive
    s4_side_d.neg_x   = !s3_abx_q[DiffW-1];
    s4_side_d.neg_y   = !s3_aby_q[DiffW-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      abx_q   <= coord_diff(in_data_i.first_start_x, in_data_i.first_end_x);
      aby_q   <= coord_diff(in_data_i.first_start_y, in_data_i.first_end_y);
      cdx_q   <= coord_diff(in_data_i.second_start_x, in_data_i.second_end_x);
      cdy_q   <= coord_diff(in_data_i.second_start_y, in_data_i.second_end_y);
      acx_q   <= coord_diff(in_data_i.first_start_x, in_data_i.second_start_x);
      acy_q   <= coord_diff(in_data_i.first_start_y, in_data_i.second_start_y);
      s1_ax_q <= in_data_i.first_start_x;
      s1_ay_q <= in_data_i.first_start_y;
      // stage 2
      p_den_a_q <= ProdW'(abx_q) * ProdW'(cdy_q);
      p_den_b_q <= ProdW'(aby_q) * ProdW'(cdx_q);
      p_t_a_q   <= ProdW'(acx_q) * ProdW'(cdy_q);
      p_t_b_q   <= ProdW'(acy_q) * ProdW'(cdx_q);
      p_u_a_q   <= ProdW'(aby_q) * ProdW'(acx_q);
      p_u_b_q   <= ProdW'(abx_q) * ProdW'(acy_q);
      s2_abx_q  <= abx_q;
      s2_aby_q  <= aby_q;
      s2_ax_q   <= s1_ax_q;
      s2_ay_q   <= s1_ay_q;
      // stage 3
      den_q    <= SumW'(p_den_a_q) - SumW'(p_den_b_q);
      tnum_q   <= SumW'(p_t_a_q) - SumW'(p_t_b_q);
      unum_q   <= SumW'(p_u_a_q) - SumW'(p_u_b_q);
      s3_abx_q <= s2_abx_q;
      s3_aby_q <= s2_aby_q;
      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      // stage 4
      tn_q      <= mag_tnum;
      dn_q      <= mag_den;
      mdx_q     <= diff_mag(s3_abx_q);
      mdy_q     <= diff_mag(s3_aby_q);
      s4_side_q <= s4_side_d;
      // stage 5
      num_x_q   <= NumW'(tn_q) * NumW'(mdx_q);
      num_y_q   <= NumW'(tn_q) * NumW'(mdy_q);
      s5_dn_q   <= dn_q;
      s5_side_q <= s4_side_q;
    end
  end

  // quotient pipeline: floor(|tnum| * |delta| * 2^FRAC_BITS / |den|)
  logic             tail_valid;
  sip_pkg::side_t   tail_side;
  logic [QuotW-1:0] quot_x, quot_y;

  sip_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (s5_valid_q),
    .side_i   (s5_side_q),
    .den_i    (s5_dn_q),
    .num_x_i  (num_x_q),
    .num_y_i  (num_y_q),
    .valid_o  (tail_valid),
    .side_o   (tail_side),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  // final placement: a * 2^FRAC_BITS plus or minus the offset, modulo 2^32
  logic [QuotW+PointW-1:0] qx_wide, qy_wide;
  logic [PointW-1:0]       off_x, off_y, base_x, base_y;
  sip_pkg::point_t         tail_result;

  always_comb begin
    qx_wide = {{PointW{1'b0}}, quot_x};
    qy_wide = {{PointW{1'b0}}, quot_y};
    off_x   = qx_wide[PointW-1:0];
    off_y   = qy_wide[PointW-1:0];
    base_x  = {{(PointW-CoordW){tail_side.start_x[CoordW-1]}}, tail_side.start_x} << FRAC_BITS;
    base_y  = {{(PointW-CoordW){tail_side.start_y[CoordW-1]}}, tail_side.start_y} << FRAC_BITS;
    tail_result.hit = tail_side.hit;
    if (tail_side.hit) begin
      tail_result.cross_x = tail_side.neg_x ? base_x - off_x : base_x + off_x;
      tail_result.cross_y = tail_side.neg_y ? base_y - off_y : base_y + off_y;
    end else begin
      tail_result.cross_x = '0;
      tail_result.cross_y = '0;
    end
  end

  // output register plus one skid entry; the skid fills only while the output is held
  logic            out_valid_q;
  sip_pkg::point_t out_data_q, skid_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      // the pipeline tail is frozen while the skid entry is full
      out_valid_q  <= skid_valid_q || tail_valid;
      skid_valid_q <= 1'b0;
    end else if (tail_valid && adv) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_data_q <= skid_valid_q ? skid_data_q : tail_result;
    end else if (adv) begin
      skid_data_q <= tail_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/sip_checker.sv
// segment intersection point: port-level checker and its bind to the top level
// depends on sip_pkg
module sip_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input sip_pkg::point_t out_data_o
);

  // a held output transaction stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // a miss carries a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.cross_x == '0 && out_data_o.cross_y == '0)
    else $error("miss with nonzero point");

  // input back-pressure only follows an output stall
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !$past(out_ready_i))
    else $error("input refused without an output stall");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
